FILE: design/tlf_pkg.sv
`timescale 1ns / 1ps

package tlf_pkg;

  // Largest matrix dimension; the store holds MaxDim * MaxDim words.
  localparam int unsigned MaxDim = 64;

  // Width of the dimension registers and of every walk counter.
  localparam int unsigned DimW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRows      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCols      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTileRows  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTileCols  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTransTile = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTransMat  = 3'd5;

  // Input beat kinds.
  localparam logic KindLoad = 1'b0;
  localparam logic KindEmit = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [11:0] load_address;
    logic [31:0] load_value;
  } in_t;

  typedef struct packed {
    logic [31:0]     element_value;
    logic            is_padding;
    logic            last_element;
    logic [DimW-1:0] outer_tile_count;
    logic [DimW-1:0] inner_tile_count;
  } out_t;

  typedef struct packed {
    logic ld_we;
    logic div_start;
    logic div_step;
    logic calc;
    logic mult;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_CALC = 6'b000100,
    S_MULT = 6'b001000,
    S_READ = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

endpackage

FILE: design/tiled_layout_flattener.sv
`timescale 1ns / 1ps

// Channel   Signals                                  Direction
// in        in_valid_i / in_ready_o / in_data_i      load or emit-request beats in
// out       out_valid_o / out_ready_i / out_data_o   tiled element beats out
// cfg       cfg_we_i / cfg_idx_i / cfg_data_i        register writes, no read-back
//
// A load beat is written into the element store in the cycle it is accepted.
// An emit request then passes through position, address multiply, store read
// and output register load; no beat is taken until that load is done. After
// reset and after a write to a listed register the first request runs the
// divider first. Reset clears control state and sets the registers; the store
// is not reset. A stalled output beat waits in its register while loads go on.

module tiled_layout_flattener (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tlf_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tlf_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [tlf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlf_pkg::CfgDataW-1:0] cfg_data_i
);

  // The controller sequences each beat through the datapath; the datapath
  // holds the registers, walk counters, divider and element store.
  tlf_pkg::cmd_t cmd;
  tlf_pkg::sts_t sts;

  tlf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_data_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: design/tlf_ctrl.sv
`timescale 1ns / 1ps

module tlf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_kind_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic                        cfg_we_i,
  input  logic [tlf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  tlf_pkg::sts_t               sts_i,
  output tlf_pkg::cmd_t               cmd_o
);

  tlf_pkg::state_e state_q, state_d;
  logic stale_q, stale_d;
  logic out_valid_q, out_valid_d;
  logic cfg_hit;

  // Only writes to a listed register change the tile counts.
  assign cfg_hit = cfg_we_i && (cfg_idx_i <= tlf_pkg::CfgTransMat);

  always_comb begin
    state_d = state_q;
    stale_d = stale_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tlf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == tlf_pkg::KindLoad) begin
            cmd_o.ld_we = 1'b1;
          end else if (stale_q) begin
            cmd_o.div_start = 1'b1;
            state_d = tlf_pkg::S_DIV;
          end else begin
            state_d = tlf_pkg::S_CALC;
          end
        end
      end
      tlf_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          stale_d = 1'b0;
          state_d = tlf_pkg::S_CALC;
        end
      end
      tlf_pkg::S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = tlf_pkg::S_MULT;
      end
      tlf_pkg::S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d = tlf_pkg::S_READ;
      end
      tlf_pkg::S_READ: begin
        cmd_o.rd = 1'b1;
        state_d = tlf_pkg::S_OUT;
      end
      tlf_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = tlf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tlf_pkg::S_IDLE;
      end
    endcase
    if (cfg_hit) begin
      stale_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlf_pkg::S_IDLE;
      stale_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stale_q <= stale_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/tlf_datapath.sv
`timescale 1ns / 1ps

module tlf_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlf_pkg::in_t                 in_data_i,
  input  logic                         cfg_we_i,
  input  logic [tlf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlf_pkg::CfgDataW-1:0] cfg_data_i,
  input  tlf_pkg::cmd_t                cmd_i,
  output tlf_pkg::sts_t                sts_o,
  output tlf_pkg::out_t                out_data_o
);

  localparam int unsigned StoreDepth = tlf_pkg::MaxDim * tlf_pkg::MaxDim;
  localparam int unsigned AddrW = $clog2(StoreDepth);
  localparam int unsigned DW = tlf_pkg::DimW;

  // Configuration registers, kept raw and saturated where they are used.
  logic [DW-1:0] rows_q, cols_q, trows_q, tcols_q;
  logic          ttile_q, tmat_q;
  logic          restart;

  // Walk counters.
  logic [DW-1:0] outer_q, inner_q, row_q, col_q;

  // Tile-count divider, one lane per direction.
  logic [7:0]    num_a_q, num_b_q, quo_a_q, quo_b_q;
  logic [DW-1:0] rem_a_q, rem_b_q;
  logic [2:0]    step_q;

  // Element pipeline.
  logic [7:0]       ridx_q, cidx_q;
  logic             last_q, pad_q, hit_q;
  logic [AddrW-1:0] addr_q;
  logic [31:0]      rdata_q;
  tlf_pkg::out_t    out_q;

  logic [31:0] mem [StoreDepth];

  function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > tlf_pkg::MaxDim) begin
      r = DW'(tlf_pkg::MaxDim);
    end
    return r;
  endfunction

  logic [DW-1:0] r_eff, c_eff, tr_eff, tc_eff;
  logic [DW-1:0] er, ec, etr, etc_w;
  logic          tm, tt;
  logic [DW-1:0] outer_n, inner_n;

  assign r_eff  = sat_dim(rows_q);
  assign c_eff  = sat_dim(cols_q);
  assign tr_eff = sat_dim(trows_q);
  assign tc_eff = sat_dim(tcols_q);
  assign tm     = tmat_q;
  assign tt     = ttile_q ^ tmat_q;
  assign er     = tm ? c_eff : r_eff;
  assign ec     = tm ? r_eff : c_eff;
  assign etr    = tm ? tc_eff : tr_eff;
  assign etc_w  = tm ? tr_eff : tc_eff;
  assign outer_n = tt ? quo_b_q[DW-1:0] : quo_a_q[DW-1:0];
  assign inner_n = tt ? quo_a_q[DW-1:0] : quo_b_q[DW-1:0];

  assign restart = cfg_we_i && (cfg_idx_i <= tlf_pkg::CfgTransMat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DW'(64);
      cols_q  <= DW'(64);
      trows_q <= DW'(8);
      tcols_q <= DW'(8);
      ttile_q <= 1'b0;
      tmat_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlf_pkg::CfgRows:      rows_q  <= cfg_data_i;
        tlf_pkg::CfgCols:      cols_q  <= cfg_data_i;
        tlf_pkg::CfgTileRows:  trows_q <= cfg_data_i;
        tlf_pkg::CfgTileCols:  tcols_q <= cfg_data_i;
        tlf_pkg::CfgTransTile: ttile_q <= cfg_data_i[0];
        tlf_pkg::CfgTransMat:  tmat_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Restoring division of (n + d - 1) by d, one quotient bit a cycle.
  logic [7:0] sh_a, sh_b;
  logic       ge_a, ge_b;

  assign sh_a = {rem_a_q, num_a_q[7]};
  assign sh_b = {rem_b_q, num_b_q[7]};
  assign ge_a = sh_a >= {1'b0, etr};
  assign ge_b = sh_b >= {1'b0, etc_w};
  assign sts_o.div_last = (step_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_a_q <= {1'b0, er} + {1'b0, etr} - 8'd1;
      num_b_q <= {1'b0, ec} + {1'b0, etc_w} - 8'd1;
      rem_a_q <= '0;
      rem_b_q <= '0;
      quo_a_q <= '0;
      quo_b_q <= '0;
    end else if (cmd_i.div_step) begin
      num_a_q <= {num_a_q[6:0], 1'b0};
      num_b_q <= {num_b_q[6:0], 1'b0};
      rem_a_q <= ge_a ? DW'(sh_a - {1'b0, etr}) : DW'(sh_a);
      rem_b_q <= ge_b ? DW'(sh_b - {1'b0, etc_w}) : DW'(sh_b);
      quo_a_q <= {quo_a_q[6:0], ge_a};
      quo_b_q <= {quo_b_q[6:0], ge_b};
    end
  end

  // Element position and walk advance.
  logic [DW-1:0] rsel, csel, trow, tcol;
  logic          last_w;
  logic          col_wrap, row_wrap, inner_wrap, outer_wrap;

  assign rsel = tm ? col_q : row_q;
  assign csel = tm ? row_q : col_q;
  assign trow = tt ? inner_q : outer_q;
  assign tcol = tt ? outer_q : inner_q;

  assign col_wrap   = ({1'b0, col_q} + 8'd1) >= {1'b0, tc_eff};
  assign row_wrap   = ({1'b0, row_q} + 8'd1) >= {1'b0, tr_eff};
  assign inner_wrap = ({1'b0, inner_q} + 8'd1) >= {1'b0, inner_n};
  assign outer_wrap = ({1'b0, outer_q} + 8'd1) >= {1'b0, outer_n};
  assign last_w     = outer_wrap && inner_wrap && row_wrap && col_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= '0;
      inner_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else if (restart || (cmd_i.calc && last_w)) begin
      outer_q <= '0;
      inner_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else if (cmd_i.calc) begin
      if (!col_wrap) begin
        col_q <= col_q + DW'(1);
      end else begin
        col_q <= '0;
        if (!row_wrap) begin
          row_q <= row_q + DW'(1);
        end else begin
          row_q <= '0;
          if (!inner_wrap) begin
            inner_q <= inner_q + DW'(1);
          end else begin
            inner_q <= '0;
            outer_q <= outer_wrap ? '0 : outer_q + DW'(1);
          end
        end
      end
    end
  end

  logic [13:0] rprod, cprod;
  logic [15:0] lin_addr;
  logic        pad_w;

  assign rprod = {7'd0, trow} * {7'd0, etr} + {7'd0, rsel};
  assign cprod = {7'd0, tcol} * {7'd0, etc_w} + {7'd0, csel};
  assign pad_w = (ridx_q >= {1'b0, er}) || (cidx_q >= {1'b0, ec});
  assign lin_addr = {8'd0, ridx_q} * {9'd0, ec} + {8'd0, cidx_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      ridx_q <= rprod[7:0];
      cidx_q <= cprod[7:0];
      last_q <= last_w;
    end
    if (cmd_i.mult) begin
      pad_q  <= pad_w;
      hit_q  <= !pad_w && (32'(lin_addr) < StoreDepth);
      addr_q <= AddrW'(lin_addr);
    end
  end

  // Element store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_we && (32'(in_data_i.load_address) < StoreDepth)) begin
      mem[AddrW'(in_data_i.load_address)] <= in_data_i.load_value;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.element_value    <= hit_q ? rdata_q : 32'd0;
      out_q.is_padding       <= pad_q;
      out_q.last_element     <= last_q;
      out_q.outer_tile_count <= outer_n;
      out_q.inner_tile_count <= inner_n;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: dv/tiled_layout_flattener_tb.sv
`timescale 1ns / 1ps

// A block of low store addresses is loaded once after reset. Entries that
// were never loaded are not checked for their value; padding, the last flag
// and the tile counts are checked everywhere. After that, every phase starts
// from an idle block; random phases get a new register setting and mix
// loads with emit requests. Each accepted beat is handed to the ledger below.
// The ledger keeps its own copy of the store, the registers and the tile
// walk, and queues the element that each emit request must produce. Every
// element beat leaving the block is checked against the oldest queued one.

module tiled_layout_flattener_tb;
  import tlf_pkg::*;

  localparam int unsigned StoreDepth = MaxDim * MaxDim;
  localparam int unsigned NumRegs = 6;
  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;
  localparam int unsigned FillDepth = 128;
  localparam int unsigned DirectedItems = 193;
  localparam int unsigned TotalItems = 800;
  localparam int unsigned PressurePhase = 2;
  localparam int unsigned HoldOffCycles = 200;
  // Covers the divider and the element pipeline, with margin.
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned CycleLimit = 2500000;

  // Mirror of the block: element store, registers, tile walk, and the queue
  // of elements that requests have asked for but that have not come out yet.
  class tile_stream_ledger;
    logic [31:0]     store [StoreDepth];
    logic [DimW-1:0] rows_q, cols_q, tile_rows_q, tile_cols_q;
    logic            trans_tiles_q, trans_mat_q;
    int unsigned     outer_idx, inner_idx, row_idx, col_idx;
    out_t            owed_elements [$];
    int unsigned     error_count;

    function new();
      rows_q = DimW'(64);
      cols_q = DimW'(64);
      tile_rows_q = DimW'(8);
      tile_cols_q = DimW'(8);
      trans_tiles_q = 1'b0;
      trans_mat_q = 1'b0;
      error_count = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      outer_idx = 0;
      inner_idx = 0;
      row_idx = 0;
      col_idx = 0;
    endfunction

    // Zero and oversized dimensions are used as if saturated into 1..MaxDim.
    function int unsigned sat_dim(logic [DimW-1:0] v);
      if (v == 0) return 1;
      if (v > MaxDim) return MaxDim;
      return 32'(v);
    endfunction

    function int unsigned footprint();
      return sat_dim(rows_q) * sat_dim(cols_q);
    endfunction

    function int unsigned pending();
      return owed_elements.size();
    endfunction

    // Any write to a real register restarts the stream; spare indexes do not.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgRows:      rows_q = data;
        CfgCols:      cols_q = data;
        CfgTileRows:  tile_rows_q = data;
        CfgTileCols:  tile_cols_q = data;
        CfgTransTile: trans_tiles_q = data[0];
        CfgTransMat:  trans_mat_q = data[0];
        default:      return;
      endcase
      restart_walk();
    endfunction

    // Works out the element at the current walk position, then steps the walk.
    function out_t next_tiled_element();
      int unsigned r, c, tr, tc, er, ec, span_r, span_c;
      int unsigned row_tiles, col_tiles, outer_n, inner_n, ridx, cidx;
      bit          tm, tt, pad, fin;
      out_t        res;
      r = sat_dim(rows_q);
      c = sat_dim(cols_q);
      tr = sat_dim(tile_rows_q);
      tc = sat_dim(tile_cols_q);
      // Matrix transpose swaps both the dimensions and the tile shape, and
      // flips the sense of the tile transpose.
      tm = trans_mat_q;
      tt = trans_tiles_q ^ trans_mat_q;
      er = tm ? c : r;
      ec = tm ? r : c;
      span_r = tm ? tc : tr;
      span_c = tm ? tr : tc;
      row_tiles = (er + span_r - 1) / span_r;
      col_tiles = (ec + span_c - 1) / span_c;
      outer_n = tt ? col_tiles : row_tiles;
      inner_n = tt ? row_tiles : col_tiles;
      ridx = (tm ? col_idx : row_idx) + (tt ? inner_idx : outer_idx) * span_r;
      cidx = (tm ? row_idx : col_idx) + (tt ? outer_idx : inner_idx) * span_c;
      pad = (ridx >= er) || (cidx >= ec);
      res.element_value = pad ? 32'h0 : store[ridx * ec + cidx];
      res.is_padding = pad;
      // The in-tile counters run over the registers as written, not swapped.
      fin = (outer_idx + 1 >= outer_n) && (inner_idx + 1 >= inner_n) &&
            (row_idx + 1 >= tr) && (col_idx + 1 >= tc);
      res.last_element = fin;
      res.outer_tile_count = outer_n[DimW-1:0];
      res.inner_tile_count = inner_n[DimW-1:0];
      if (fin) begin
        restart_walk();
      end else begin
        col_idx++;
        if (col_idx >= tc) begin
          col_idx = 0;
          row_idx++;
          if (row_idx >= tr) begin
            row_idx = 0;
            inner_idx++;
            if (inner_idx >= inner_n) begin
              inner_idx = 0;
              outer_idx++;
              if (outer_idx >= outer_n) outer_idx = 0;
            end
          end
        end
      end
      return res;
    endfunction

    // Loads land in the store at once; requests queue the element they owe.
    function void note_beat(in_t beat);
      out_t due;
      if (beat.kind == KindLoad) begin
        store[beat.load_address] = beat.load_value;
      end else begin
        due = next_tiled_element();
        owed_elements = {owed_elements, due};
      end
    endfunction

    function void check_element(out_t got);
      out_t want;
      if (owed_elements.size() == 0) begin
        $error("element beat %h arrived with no request outstanding", got);
        error_count++;
        return;
      end
      want = owed_elements.pop_front();
      // An element read from a never-loaded entry has no defined value.
      if (!$isunknown(want.element_value) &&
          got.element_value !== want.element_value) begin
        $error("element_value: expected %h, got %h", want.element_value, got.element_value);
        error_count++;
      end
      if (got.is_padding !== want.is_padding) begin
        $error("is_padding: expected %b, got %b", want.is_padding, got.is_padding);
        error_count++;
      end
      if (got.last_element !== want.last_element) begin
        $error("last_element: expected %b, got %b", want.last_element, got.last_element);
        error_count++;
      end
      if (got.outer_tile_count !== want.outer_tile_count) begin
        $error("outer_tile_count: expected %0d, got %0d",
               want.outer_tile_count, got.outer_tile_count);
        error_count++;
      end
      if (got.inner_tile_count !== want.inner_tile_count) begin
        $error("inner_tile_count: expected %0d, got %0d",
               want.inner_tile_count, got.inner_tile_count);
        error_count++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tile_stream_ledger sb = new();

  // When steady is set, neither side inserts gaps. Setting squeeze asks the
  // output side for one long hold-off while the input side keeps offering.
  bit steady;
  bit squeeze;

  tiled_layout_flattener dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Most gaps are zero or short; a few are long enough to drain or fill
  // the block completely.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_word();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 32'hFFFF_FFFF;
    if (roll == 1) return 32'h0;
    return $urandom;
  endfunction

  // Dimension values: mostly small, sometimes zero, oversized or full size.
  function automatic int unsigned dim_value(input int unsigned small_max);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(MaxDim + 1, 127);
    if (roll == 2) return MaxDim;
    return $urandom_range(1, small_max);
  endfunction

  // An optional gap, then the beat is held until the block takes it.
  task automatic send_beat(input in_t beat);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(beat);
  endtask

  task automatic send_load(input logic [11:0] addr, input logic [31:0] value);
    in_t beat;
    beat.kind = KindLoad;
    beat.load_address = addr;
    beat.load_value = value;
    send_beat(beat);
  endtask

  // The address and value fields of a request carry noise; the block
  // must not look at them.
  task automatic send_emit();
    in_t beat;
    beat.kind = KindEmit;
    beat.load_address = 12'($urandom);
    beat.load_value = $urandom;
    send_beat(beat);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_config(input int unsigned r, input int unsigned c,
                              input int unsigned tr, input int unsigned tc,
                              input int unsigned tt, input int unsigned tm);
    write_reg(CfgRows, CfgDataW'(r));
    write_reg(CfgCols, CfgDataW'(c));
    write_reg(CfgTileRows, CfgDataW'(tr));
    write_reg(CfgTileCols, CfgDataW'(tc));
    write_reg(CfgTransTile, CfgDataW'(tt));
    write_reg(CfgTransMat, CfgDataW'(tm));
  endtask

  // Rewrites a random subset of the registers, starting at a random index.
  // Mode registers get full 7-bit values, so the upper bits are exercised.
  task automatic random_config();
    int unsigned        first;
    logic [CfgIdxW-1:0] idx;
    first = $urandom_range(0, NumRegs - 1);
    for (int unsigned k = 0; k < NumRegs; k++) begin
      idx = CfgIdxW'((first + k) % NumRegs);
      if ($urandom_range(0, 1)) begin
        case (idx)
          CfgRows, CfgCols:         write_reg(idx, CfgDataW'(dim_value(9)));
          CfgTileRows, CfgTileCols: write_reg(idx, CfgDataW'(dim_value(4)));
          default:                  write_reg(idx, CfgDataW'($urandom_range(0, 127)));
        endcase
      end
    end
    if ($urandom_range(0, 5) == 0)
      write_reg($urandom_range(0, 1) ? CfgUnusedLo : CfgUnusedHi,
                CfgDataW'($urandom_range(0, 127)));
  endtask

  // Mixed loads and requests. Half of the loads hit the live part of the
  // matrix, so they change elements that the walk reads later.
  task automatic run_phase(input int unsigned n_items);
    int unsigned span;
    span = sb.footprint();
    for (int unsigned k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        send_load(12'($urandom_range(0, 1) ? $urandom_range(0, span - 1)
                                           : $urandom_range(0, 4095)),
                  random_word());
      end else begin
        send_emit();
      end
    end
  endtask

  // Waits until every owed element has come out, then lets the divider and
  // pipeline go quiet before anything touches the registers.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_element(out_data_o);
  end

  // Output side pacing: bursts of ready with random gaps between them, and
  // one long hold-off on request so the block backs up into its input.
  initial begin : sink_pacing
    int unsigned gap;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      gap = idle_gap();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned done_items;
    int unsigned phase;
    int unsigned n_items;
    steady = 1'b0;
    squeeze = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgRows;
    cfg_data_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the low block of the store once. Its first and last addresses
    // carry the all-ones and all-zero words.
    for (int unsigned a = 0; a < FillDepth; a++) begin
      send_load(a[11:0], (a == 0) ? 32'hFFFF_FFFF :
                         (a == FillDepth - 1) ? 32'h0 : $urandom);
    end

    // Registers still hold their reset values: 64 by 64 in 8 by 8 tiles.
    repeat (6) send_emit();
    settle();
    // A write to a spare index is dropped and must not restart the walk.
    write_reg(CfgUnusedLo, 7'h55);
    repeat (2) send_emit();
    settle();

    // A 3 by 2 matrix in 2 by 2 tiles: the second tile row is half padding.
    // The load in the middle of the walk changes row 2, column 1 just
    // before it is read. The ninth request wraps back to the first element.
    apply_config(3, 2, 2, 2, 0, 0);
    repeat (5) send_emit();
    send_load(12'd5, 32'hA5A5_0F0F);
    repeat (4) send_emit();
    settle();

    // Extreme settings. Zero and oversized dimensions saturate; the mode
    // registers only look at bit zero.
    apply_config(0, 127, 0, 127, 7'h7E, 7'h00);
    repeat (66) send_emit();
    settle();
    apply_config(MaxDim, 1, 1, 1, 7'h7F, 7'h03);
    repeat (66) send_emit();
    settle();
    apply_config(MaxDim, MaxDim, MaxDim, MaxDim, 0, 1);
    repeat (40) send_emit();
    settle();
    apply_config(1, 1, 1, 1, 7'h02, 7'h01);
    repeat (3) send_emit();
    done_items = FillDepth + DirectedItems;

    // Random phases: a fresh register setting each time, then a mix of
    // loads and requests. One phase runs against a long output hold-off.
    phase = 0;
    while (done_items < TotalItems) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      random_config();
      n_items = $urandom_range(20, 100);
      if (phase == PressurePhase) begin
        steady = 1'b1;
        squeeze = 1'b1;
        n_items = 120;
      end
      run_phase(n_items);
      done_items += n_items;
      phase++;
    end

    settle();
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: tiled_layout_flattener.f
design/tlf_pkg.sv
design/tlf_ctrl.sv
design/tlf_datapath.sv
design/tiled_layout_flattener.sv
dv/tiled_layout_flattener_tb.sv
